// ----- hw/rtl/sclru_pkg.sv -----
// ----------------------------------------------------------------------------
// Sector cache LRU tag engine package
// Shared widths, defaults and the result flag bundle of the sector cache
// tag and replacement engine.
// ----------------------------------------------------------------------------
package sclru_pkg;

  // Width of the slot field in a result.
  localparam int SLOT_W = 5;

  // Width of the capacity register.
  localparam int CFG_W = 6;

  // Default build sizes.
  localparam int DEF_NUM_SLOTS   = 32;
  localparam int DEF_SECTOR_BITS = 24;

  // Capacity after reset.
  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(32);

  // Result flags handed from the engine to the top level.
  typedef struct packed {
    logic              hit;
    logic              evicted_valid;
    logic [SLOT_W-1:0] slot;
  } res_flags_t;

endpackage

// ----- hw/rtl/sector_cache_lru_tags_top.sv -----
// ----------------------------------------------------------------------------
// Sector cache LRU tag engine
// Tag lookup and least recently used replacement for a fully associative
// disk-sector cache, with a capacity register.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low; busy then stays
// high until the result appears. The filled entries of the single entry
// memory are swept once to search and, except on a lookup miss, once more
// to write back recency ranks. The result is shown for exactly one cycle
// with done high and cannot be held off, so the receiver must capture it
// then. A new transaction may start in the cycle of the strobe. The
// capacity register is written through cfg_valid/cfg_data, which is always
// ready, and should be written only while busy is low.
module sector_cache_lru_tags_top #(
  parameter int NUM_SLOTS   = sclru_pkg::DEF_NUM_SLOTS,
  parameter int SECTOR_BITS = sclru_pkg::DEF_SECTOR_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic                         mode,
  input  logic [SECTOR_BITS-1:0]       sector_number,
  output logic                         done,
  output logic                         hit,
  output logic [sclru_pkg::SLOT_W-1:0] slot,
  output logic                         evicted_valid,
  output logic [SECTOR_BITS-1:0]       evicted_sector,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [sclru_pkg::CFG_W-1:0]  cfg_data
);
  import sclru_pkg::*;

  localparam int CNT_W = $clog2(NUM_SLOTS + 1);

  logic [CFG_W-1:0] active_slots;
  logic [CNT_W-1:0] cap;
  res_flags_t       flags;

  assign cfg_ready = 1'b1;

  // Capacity register.
  always_ff @(posedge clk) begin
    if (rst) begin
      active_slots <= CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      active_slots <= cfg_data;
    end
  end

  // Clamp the capacity to 1..NUM_SLOTS.
  always_comb begin
    priority if (active_slots == '0) begin
      cap = CNT_W'(1);
    end else if (int'(active_slots) > NUM_SLOTS) begin
      cap = CNT_W'(NUM_SLOTS);
    end else begin
      cap = CNT_W'(active_slots);
    end
  end

  sclru_engine #(
    .NUM_SLOTS   (NUM_SLOTS),
    .SECTOR_BITS (SECTOR_BITS)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .start     (start && !busy),
    .mode      (mode),
    .key       (sector_number),
    .cap       (cap),
    .busy      (busy),
    .done      (done),
    .flags     (flags),
    .ev_sector (evicted_sector)
  );

  assign hit           = flags.hit;
  assign slot          = flags.slot;
  assign evicted_valid = flags.evicted_valid;

endmodule

// ----- hw/rtl/sclru_engine.sv -----
// ----------------------------------------------------------------------------
// Sector cache LRU tag engine core
// Holds tags and recency ranks in one synchronous memory. Filled entries are
// swept once to search and, except on a lookup miss, again to update ranks.
// ----------------------------------------------------------------------------
module sclru_engine #(
  parameter int NUM_SLOTS   = sclru_pkg::DEF_NUM_SLOTS,
  parameter int SECTOR_BITS = sclru_pkg::DEF_SECTOR_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          mode,
  input  logic [SECTOR_BITS-1:0]        key,
  input  logic [$clog2(NUM_SLOTS+1)-1:0] cap,
  output logic                          busy,
  output logic                          done,
  output sclru_pkg::res_flags_t         flags,
  output logic [SECTOR_BITS-1:0]        ev_sector
);
  import sclru_pkg::*;

  localparam int IDX_W  = $clog2(NUM_SLOTS);
  localparam int CNT_W  = $clog2(NUM_SLOTS + 1);
  localparam int RANK_W = IDX_W;
  localparam int ENT_W  = RANK_W + SECTOR_BITS;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SEARCH = 4'b0010,
    ST_DECIDE = 4'b0100,
    ST_UPDATE = 4'b1000
  } state_t;

  state_t state;

  // Entry memory: recency rank above the tag, rank 0 is most recent.
  logic [ENT_W-1:0] mem [NUM_SLOTS];
  logic [ENT_W-1:0] rd_data;
  logic [IDX_W-1:0] rd_addr;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [ENT_W-1:0] mem_wdata;

  // Sweep control and the captured transaction.
  logic [CNT_W-1:0]       cnt;
  logic [CNT_W-1:0]       n;
  logic [CNT_W-1:0]       fill_count;
  logic                   mode_q;
  logic [SECTOR_BITS-1:0] key_q;

  // Search results.
  logic                   hit_found;
  logic [IDX_W-1:0]       hit_idx;
  logic [RANK_W-1:0]      hit_rank;
  logic [IDX_W-1:0]       old_idx;
  logic [SECTOR_BITS-1:0] old_tag;

  // Update plan.
  logic [IDX_W-1:0]  sel_idx;
  logic [RANK_W-1:0] sel_rank;
  logic              age_all;
  logic              replace;

  // Entry seen at the memory output during a sweep.
  logic [IDX_W-1:0]       chk_idx;
  logic [RANK_W-1:0]      chk_rank;
  logic [SECTOR_BITS-1:0] chk_tag;
  logic                   do_append;
  logic [RANK_W-1:0]      upd_rank;
  logic [SECTOR_BITS-1:0] upd_tag;

  assign busy = (state != ST_IDLE);

  assign chk_idx  = IDX_W'(cnt - 1'b1);
  assign chk_rank = rd_data[ENT_W-1:SECTOR_BITS];
  assign chk_tag  = rd_data[SECTOR_BITS-1:0];
  assign rd_addr  = (cnt < n) ? IDX_W'(cnt) : '0;

  assign do_append = mode_q && !hit_found && (fill_count < cap);

  // New rank and tag of the entry being written back in the update sweep.
  always_comb begin
    upd_rank = chk_rank;
    upd_tag  = chk_tag;
    if (!age_all && chk_idx == sel_idx) begin
      upd_rank = '0;
      if (replace) begin
        upd_tag = key_q;
      end
    end else if (age_all || chk_rank < sel_rank) begin
      upd_rank = chk_rank + 1'b1;
    end
  end

  // Memory write port: append in the decide cycle, write-back while updating.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = chk_idx;
    mem_wdata = {upd_rank, upd_tag};
    if (state == ST_DECIDE && do_append) begin
      mem_we    = 1'b1;
      mem_waddr = IDX_W'(fill_count);
      mem_wdata = {RANK_W'(0), key_q};
    end else if (state == ST_UPDATE && cnt != '0) begin
      mem_we = 1'b1;
    end
  end

  // Synchronous memory with a registered read.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[rd_addr];
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      fill_count <= '0;
      done       <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            mode_q    <= mode;
            key_q     <= key;
            n         <= fill_count;
            cnt       <= '0;
            hit_found <= 1'b0;
            state     <= ST_SEARCH;
          end
        end
        ST_SEARCH: begin
          // Compare the entry that the previous read brought out.
          if (cnt != '0) begin
            if (!hit_found && chk_tag == key_q) begin
              hit_found <= 1'b1;
              hit_idx   <= chk_idx;
              hit_rank  <= chk_rank;
            end
            // Ranks of filled entries form 0..n-1, so the oldest holds n-1.
            if (chk_rank == RANK_W'(n - 1'b1)) begin
              old_idx <= chk_idx;
              old_tag <= chk_tag;
            end
          end
          if (cnt == n) begin
            state <= ST_DECIDE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_DECIDE: begin
          cnt       <= '0;
          ev_sector <= '0;
          flags     <= '0;
          if (hit_found) begin
            // Refresh the matching entry.
            sel_idx    <= hit_idx;
            sel_rank   <= hit_rank;
            age_all    <= 1'b0;
            replace    <= 1'b0;
            flags.hit  <= 1'b1;
            flags.slot <= SLOT_W'(hit_idx);
            state      <= ST_UPDATE;
          end else if (!mode_q) begin
            // Lookup miss leaves the entries and their ranks as they are.
            done  <= 1'b1;
            state <= ST_IDLE;
          end else if (do_append) begin
            // Fresh slot: every filled entry ages by one.
            age_all    <= 1'b1;
            replace    <= 1'b0;
            fill_count <= fill_count + 1'b1;
            flags.slot <= SLOT_W'(fill_count);
            state      <= ST_UPDATE;
          end else begin
            // Full: the oldest entry takes the new sector.
            sel_idx             <= old_idx;
            sel_rank            <= RANK_W'(n - 1'b1);
            age_all             <= 1'b0;
            replace             <= 1'b1;
            flags.evicted_valid <= 1'b1;
            flags.slot          <= SLOT_W'(old_idx);
            ev_sector           <= old_tag;
            state               <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          if (cnt == n) begin
            done  <= 1'b1;
            state <= ST_IDLE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
